// ===== src/canonical_kmer_stream_assert.svh =====
// ----------------------------------------------------------------------------
// canonical_kmer_stream_assert.svh
// Assertion macros shared by the canonical k-mer stream modules.
// ----------------------------------------------------------------------------
`ifndef CANONICAL_KMER_STREAM_ASSERT_SVH
`define CANONICAL_KMER_STREAM_ASSERT_SVH

// property holds at every edge outside reset
`define CKS_ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("canonical_kmer_stream: assertion failed");

// consequent holds in the same cycle as the antecedent
`define CKS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("canonical_kmer_stream: assertion failed");

// consequent holds in the cycle after the antecedent
`define CKS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("canonical_kmer_stream: assertion failed");

`endif

// ===== src/cks_pkg.sv =====
// ----------------------------------------------------------------------------
// cks_pkg
// Widths, defaults and the queued job type of the canonical k-mer stream.
// ----------------------------------------------------------------------------
package cks_pkg;

  localparam int KMER_W          = 64;  // output k-mer width
  localparam int CHAR_W          = 8;
  localparam int K_W             = 6;   // width of k and of kmer_length
  localparam int SEEN_W          = 6;   // base counter width
  localparam int SEEN_MAX        = 63;  // counter saturation value
  localparam int DEF_KMER_LENGTH = 31;
  localparam int DEF_MAX_BASES   = 32;
  localparam int DEF_QUEUE_DEPTH = 2;
  localparam int SHIFT_W         = 7;   // holds shift amounts 0..64

  // one request handed from the front to the back
  // fwd: forward word, newest base lowest, placed at the top of the field
  // rev: complement word, newest base highest, placed at the top of the field
  typedef struct packed {
    logic [KMER_W-1:0] fwd;
    logic [KMER_W-1:0] rev;
    logic [K_W-1:0]    k;
  } cks_job_t;

endpackage

// ===== src/cks_in_if.sv =====
// ----------------------------------------------------------------------------
// cks_in_if
// Input channel: one nucleotide character per request.
// ----------------------------------------------------------------------------
interface cks_in_if
  import cks_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] base_char;
  logic              seq_start;

  modport source (output valid, output base_char, output seq_start, input ready);
  modport sink   (input valid, input base_char, input seq_start, output ready);
endinterface

// ===== src/cks_out_if.sv =====
// ----------------------------------------------------------------------------
// cks_out_if
// Output channel: forward, twin and canonical k-mer per request.
// ----------------------------------------------------------------------------
interface cks_out_if
  import cks_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KMER_W-1:0] forward_kmer;
  logic [KMER_W-1:0] twin_kmer;
  logic [KMER_W-1:0] canonical_kmer;

  modport source (output valid, output forward_kmer, output twin_kmer,
                  output canonical_kmer, input ready);
  modport sink   (input valid, input forward_kmer, input twin_kmer,
                  input canonical_kmer, output ready);
endinterface

// ===== src/cks_front.sv =====
// ----------------------------------------------------------------------------
// cks_front
// Accepts characters, encodes them, shifts both k-mer words, counts bases
// and queues a job whenever a full k-mer is present.
// ----------------------------------------------------------------------------
module cks_front
  import cks_pkg::*;
#(
  parameter int MAX_BASES = DEF_MAX_BASES
) (
  input  logic           clk,
  input  logic           rst,
  cks_in_if.sink         seq_in,
  input  logic           cfg_we,
  input  logic [K_W-1:0] cfg_wdata,
  input  logic           q_full,
  output logic           q_push,
  output cks_job_t       q_job
);

  localparam int WORD_W = 2 * MAX_BASES;

  logic [K_W-1:0]    kmer_length;
  logic [WORD_W-1:0] fwd_word;
  logic [WORD_W-1:0] rev_word;
  logic [SEEN_W-1:0] bases_seen;

  logic [K_W-1:0]    k_eff;
  logic [1:0]        code;
  logic              accept;
  logic [WORD_W-1:0] fwd_base, rev_base;
  logic [WORD_W-1:0] fwd_word_next, rev_word_next;
  logic [SEEN_W-1:0] seen_base, bases_seen_next;

  always_comb begin
    priority if (kmer_length == '0) begin
      k_eff = K_W'(1);
    end else if (kmer_length > K_W'(MAX_BASES)) begin
      k_eff = K_W'(MAX_BASES);
    end else begin
      k_eff = kmer_length;
    end
  end

  // A=0 C=1 G=2 T=3 from character bits 2 and 1, case-blind
  assign code = {seq_in.base_char[2], seq_in.base_char[2] ^ seq_in.base_char[1]};

  assign seq_in.ready = !q_full;
  assign accept       = seq_in.valid && seq_in.ready;

  always_comb begin
    fwd_base  = seq_in.seq_start ? '0 : fwd_word;
    rev_base  = seq_in.seq_start ? '0 : rev_word;
    seen_base = seq_in.seq_start ? '0 : bases_seen;
    fwd_word_next = {fwd_base[WORD_W-3:0], code};
    rev_word_next = {~code, rev_base[WORD_W-1:2]};
    bases_seen_next = (seen_base == SEEN_W'(SEEN_MAX)) ? seen_base
                                                       : seen_base + 1'b1;
  end

  assign q_push    = accept && (bases_seen_next >= SEEN_W'(k_eff));
  assign q_job.fwd = KMER_W'(fwd_word_next) << (KMER_W - WORD_W);
  assign q_job.rev = KMER_W'(rev_word_next) << (KMER_W - WORD_W);
  assign q_job.k   = k_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length <= K_W'(DEF_KMER_LENGTH);
      fwd_word    <= '0;
      rev_word    <= '0;
      bases_seen  <= '0;
    end else begin
      if (cfg_we) begin
        kmer_length <= cfg_wdata;
      end
      if (accept) begin
        fwd_word   <= fwd_word_next;
        rev_word   <= rev_word_next;
        bases_seen <= bases_seen_next;
      end
    end
  end

endmodule

// ===== src/cks_queue.sv =====
// ----------------------------------------------------------------------------
// cks_queue
// Short register FIFO of jobs between the front and the back.
// ----------------------------------------------------------------------------
`include "canonical_kmer_stream_assert.svh"

module cks_queue
  import cks_pkg::*;
#(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  cks_job_t push_job,
  output logic     full,
  input  logic     pop,
  output cks_job_t pop_job,
  output logic     has_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cks_job_t         entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign has_item = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && has_item;
  assign pop_job  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `CKS_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(DEPTH))
  `CKS_ASSERT_NEXT(a_push_grows, clk, rst, do_push && !do_pop, count == CNT_W'($past(count) + 1'b1))
  `CKS_ASSERT_NEXT(a_pop_shrinks, clk, rst, do_pop && !do_push, count == CNT_W'($past(count) - 1'b1))

endmodule

// ===== src/cks_back.sv =====
// ----------------------------------------------------------------------------
// cks_back
// Aligns and masks the queued words to k bases, then picks the canonical
// k-mer and holds the result until it is taken.
// ----------------------------------------------------------------------------
`include "canonical_kmer_stream_assert.svh"

module cks_back
  import cks_pkg::*;
#(
  parameter int MAX_BASES = DEF_MAX_BASES
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_has_item,
  input  cks_job_t q_job,
  output logic     q_pop,
  cks_out_if.source kmer_out
);

  localparam int WORD_W = 2 * MAX_BASES;

  logic               s1_valid;
  logic [KMER_W-1:0]  s1_fwd, s1_tw;
  logic               o_valid;
  logic [KMER_W-1:0]  o_fwd, o_tw, o_canon;

  logic               out_adv, s1_adv;
  logic [SHIFT_W-1:0] fwd_shamt, mask_shamt;
  logic [KMER_W-1:0]  fwd_aligned, tw_masked;

  assign out_adv = !o_valid || kmer_out.ready;
  assign s1_adv  = !s1_valid || out_adv;
  assign q_pop   = q_has_item && s1_adv;

  // forward word: move the low k bases to the top; twin: keep the top k bases
  assign fwd_shamt   = SHIFT_W'(WORD_W) - {q_job.k, 1'b0};
  assign mask_shamt  = {q_job.k, 1'b0};
  assign fwd_aligned = q_job.fwd << fwd_shamt;
  assign tw_masked   = q_job.rev & ~({KMER_W{1'b1}} >> mask_shamt);

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_fwd <= fwd_aligned;
      s1_tw  <= tw_masked;
    end
    if (out_adv) begin
      o_fwd   <= s1_fwd;
      o_tw    <= s1_tw;
      o_canon <= (s1_tw < s1_fwd) ? s1_tw : s1_fwd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid <= q_has_item;
      end
      if (out_adv) begin
        o_valid <= s1_valid;
      end
    end
  end

  assign kmer_out.valid          = o_valid;
  assign kmer_out.forward_kmer   = o_fwd;
  assign kmer_out.twin_kmer      = o_tw;
  assign kmer_out.canonical_kmer = o_canon;

  `CKS_ASSERT_NEXT(a_pop_loads_s1, clk, rst, q_pop, s1_valid)
  `CKS_ASSERT_IMPLIES(a_canon_pick, clk, rst, o_valid, (o_canon == o_fwd) || (o_canon == o_tw))
  `CKS_ASSERT_IMPLIES(a_canon_min, clk, rst, o_valid, (o_canon <= o_fwd) && (o_canon <= o_tw))

endmodule

// ===== src/canonical_kmer_stream.sv =====
// ----------------------------------------------------------------------------
// canonical_kmer_stream
// Streaming canonical k-mer extractor for 2-bit DNA. One character request
// enters per cycle while the queue is not full; seq_start marks the first
// base of a new sequence. Once k bases of the current sequence are in,
// every base yields a result with the forward k-mer, its reverse complement
// and the smaller of the two, all left-justified in 64 bits. The sustained
// rate is one request per cycle on both channels while the output is not
// stalled, as the front updates both shift words per character taken. A
// result passes through the queue, the align stage and the output register.
// kmer_length (k) is written through cfg_we/cfg_wdata by the user only while
// the block is idle; the block itself leaves this unchecked. 0 acts as 1 and
// values above MAX_BASES act as MAX_BASES.
// ----------------------------------------------------------------------------
module canonical_kmer_stream
  import cks_pkg::*;
#(
  parameter int MAX_BASES   = DEF_MAX_BASES,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  cks_in_if.sink         seq_in,
  cks_out_if.source      kmer_out,
  input  logic           cfg_we,
  input  logic [K_W-1:0] cfg_wdata
);

  logic     q_push, q_full, q_pop, q_has_item;
  cks_job_t push_job, pop_job;

  cks_front #(
    .MAX_BASES (MAX_BASES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .seq_in    (seq_in),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  cks_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .has_item (q_has_item)
  );

  cks_back #(
    .MAX_BASES (MAX_BASES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_has_item (q_has_item),
    .q_job      (pop_job),
    .q_pop      (q_pop),
    .kmer_out   (kmer_out)
  );

endmodule
